### src/ppir_pkg.sv
// Package for the price position in range block: state machine type and fixed constants.
// No dependencies; used by the top level by scoped names.
`default_nettype none

package ppir_pkg;

  // Fixed widths of the input price fields and of the lookback register.
  localparam int IN_BITS       = 32;
  localparam int LOOKBACK_BITS = 9;

  // Lookback register value after reset, in bars.
  localparam logic [LOOKBACK_BITS-1:0] LOOKBACK_RESET = 9'd20;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

### src/ppir_ring.sv
// Ring memory holding the high and low of recent bars as one packed word per slot.
// One write port, one read port with registered read data; no dependencies.
`default_nettype none

module ppir_ring #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; read data is registered and valid in the cycle after the request.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/ppir_div.sv
// Restoring fraction divider: floor(num * 2^FRAC_BITS / den) for num < den, one bit a cycle.
// No dependencies; started and read by the top level.
`default_nettype none

module ppir_div #(
  parameter int NUM_BITS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [NUM_BITS-1:0]  num,
  input  wire logic [NUM_BITS-1:0]  den,
  output logic                      done,
  output logic      [FRAC_BITS-1:0] quo
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NUM_BITS:0]    rem_r, rem_nxt;
  logic [NUM_BITS-1:0]  den_r, den_nxt;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [NUM_BITS:0]    shifted;

  // One restoring step per cycle while busy.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    shifted  = {rem_r[NUM_BITS-1:0], 1'b0};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(FRAC_BITS);
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

### src/price_position_in_range_core.sv
// Price position in range (stochastic %K): top level with sequencer, range scan and output register.
// Depends on ppir_pkg, ppir_ring and ppir_div.
`default_nettype none

// Each accepted bar word is written into a ring memory of WINDOW_DEPTH slots, then the
// older bars of the window are read back one per cycle to find the highest high and the
// lowest low, and finally (close - low) / (high - low) is formed by a one-bit-per-cycle
// divider as a fraction with FRACTION_BITS fraction bits, saturated to 0 .. 1.0 and set to
// one half when the range is flat. The window holds at most the lookback register's count of
// bars, at most WINDOW_DEPTH bars and at most the bars seen so far; the scan goes through the
// memory's single read port. One bar is worked on at a time; the next bar is taken while a
// finished result still waits in the output register. The lookback register may be written
// only while the block is idle; zero acts as one.

module price_position_in_range_core #(
  parameter int WINDOW_DEPTH  = 256,
  parameter int PRICE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Bar input channel.
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [ppir_pkg::IN_BITS-1:0]         in_bar_high,
  input  wire logic [ppir_pkg::IN_BITS-1:0]         in_bar_low,
  input  wire logic [ppir_pkg::IN_BITS-1:0]         in_bar_close,
  // Result channel.
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [FRACTION_BITS:0]               out_range_position,
  // Lookback register write channel.
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ppir_pkg::LOOKBACK_BITS-1:0]   cfg_lookback_bars
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int LB_W   = ppir_pkg::LOOKBACK_BITS;
  localparam int CW     = (CNT_W > LB_W) ? CNT_W : LB_W;
  localparam int RES_W  = FRACTION_BITS + 1;

  localparam logic [RES_W-1:0] RES_FULL = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [RES_W-1:0] RES_MID  = {2'b01, {(FRACTION_BITS-1){1'b0}}};

  ppir_pkg::state_t state_r, state_nxt;

  logic [LB_W-1:0]       lookback_r;
  logic [SLOT_W-1:0]     write_slot_r, write_slot_nxt;
  logic [CNT_W-1:0]      bars_seen_r, bars_seen_nxt;
  logic [SLOT_W-1:0]     ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [PRICE_BITS-1:0] hi_r, hi_nxt;
  logic [PRICE_BITS-1:0] lo_r, lo_nxt;
  logic [PRICE_BITS-1:0] close_r, close_nxt;
  logic [RES_W-1:0]      res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]      out_pos_r, out_pos_nxt;

  logic                  in_acc;
  logic                  need_div;
  logic                  load_out;
  logic                  rd_en;
  logic                  div_start;
  logic                  div_done;
  logic [FRACTION_BITS-1:0] div_quo;

  logic [PRICE_BITS-1:0]   bar_h, bar_l, bar_c;
  logic [2*PRICE_BITS-1:0] rd_data;
  logic [PRICE_BITS-1:0]   rd_high, rd_low;
  logic [CW-1:0]           win_len;

  assign bar_h   = PRICE_BITS'(in_bar_high);
  assign bar_l   = PRICE_BITS'(in_bar_low);
  assign bar_c   = PRICE_BITS'(in_bar_close);
  assign rd_high = rd_data[2*PRICE_BITS-1:PRICE_BITS];
  assign rd_low  = rd_data[PRICE_BITS-1:0];
  assign in_acc  = in_valid && in_ready;

  // Ring of bar highs and lows.
  ppir_ring #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH (2 * PRICE_BITS),
    .AW    (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (write_slot_r),
    .wr_data ({bar_h, bar_l}),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  // Fraction divider.
  ppir_div #(
    .NUM_BITS  (PRICE_BITS),
    .FRAC_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (close_r - lo_r),
    .den   (hi_r - lo_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Range decision once the scan has finished.
  assign need_div = (hi_r > lo_r) && (close_r > lo_r) && (close_r < hi_r);

  // Window length for a new bar: lookback with zero as one, clamped to depth and bars seen.
  always_comb begin
    win_len = CW'(lookback_r);
    if (win_len == '0) begin
      win_len = CW'(1);
    end
    if (win_len > CW'(WINDOW_DEPTH)) begin
      win_len = CW'(WINDOW_DEPTH);
    end
    if (win_len > CW'(bars_seen_nxt)) begin
      win_len = CW'(bars_seen_nxt);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppir_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ppir_pkg::ST_SCAN;
        end
      end
      ppir_pkg::ST_SCAN: begin
        if (rem_r == '0 && !rd_vld_r) begin
          state_nxt = ppir_pkg::ST_EVAL;
        end
      end
      ppir_pkg::ST_EVAL: begin
        state_nxt = need_div ? ppir_pkg::ST_DIV : ppir_pkg::ST_OUT;
      end
      ppir_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = ppir_pkg::ST_OUT;
        end
      end
      ppir_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ppir_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppir_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = (state_r == ppir_pkg::ST_IDLE);
    rd_en     = (state_r == ppir_pkg::ST_SCAN) && (rem_r != '0);
    div_start = (state_r == ppir_pkg::ST_EVAL) && need_div;
    load_out  = (state_r == ppir_pkg::ST_OUT) && (!out_valid_r || out_ready);
  end

  // Ring pointers and bar count for an accepted word.
  always_comb begin
    write_slot_nxt = write_slot_r;
    bars_seen_nxt  = bars_seen_r;
    if (in_acc) begin
      write_slot_nxt = (write_slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                    : write_slot_r + SLOT_W'(1);
      if (bars_seen_r != CNT_W'(WINDOW_DEPTH)) begin
        bars_seen_nxt = bars_seen_r + CNT_W'(1);
      end
    end
  end

  // Scan and result datapath.
  always_comb begin
    ptr_nxt    = ptr_r;
    rem_nxt    = rem_r;
    rd_vld_nxt = 1'b0;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    close_nxt  = close_r;
    res_nxt    = res_r;
    if (in_acc) begin
      // The current bar seeds the range; older bars are read from the previous slot back.
      hi_nxt    = bar_h;
      lo_nxt    = bar_l;
      close_nxt = bar_c;
      rem_nxt   = CNT_W'(win_len - CW'(1));
      ptr_nxt   = (write_slot_r == '0) ? SLOT_W'(WINDOW_DEPTH - 1) : write_slot_r - SLOT_W'(1);
    end
    if (rd_en) begin
      rem_nxt    = rem_r - CNT_W'(1);
      ptr_nxt    = (ptr_r == '0) ? SLOT_W'(WINDOW_DEPTH - 1) : ptr_r - SLOT_W'(1);
      rd_vld_nxt = 1'b1;
    end
    if (rd_vld_r) begin
      if (rd_high > hi_r) begin
        hi_nxt = rd_high;
      end
      if (rd_low < lo_r) begin
        lo_nxt = rd_low;
      end
    end
    if (state_r == ppir_pkg::ST_EVAL) begin
      if (hi_r <= lo_r) begin
        res_nxt = RES_MID;
      end else if (close_r <= lo_r) begin
        res_nxt = '0;
      end else if (close_r >= hi_r) begin
        res_nxt = RES_FULL;
      end
    end
    if (div_done) begin
      res_nxt = RES_W'(div_quo);
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = res_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppir_pkg::ST_IDLE;
      lookback_r   <= ppir_pkg::LOOKBACK_RESET;
      write_slot_r <= '0;
      bars_seen_r  <= '0;
      rem_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_slot_r <= write_slot_nxt;
      bars_seen_r  <= bars_seen_nxt;
      rem_r        <= rem_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        lookback_r <= cfg_lookback_bars;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    close_r   <= close_nxt;
    res_r     <= res_nxt;
    out_pos_r <= out_pos_nxt;
  end

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_range_position = out_pos_r;

endmodule

`default_nettype wire
